// File: rtl/keyframe_linear_interp_core_macros.svh
// Assertion macros for the keyframe interpolation core.
// Used by the top level; no other dependencies.
`ifndef KEYFRAME_LINEAR_INTERP_CORE_MACROS_SVH
`define KEYFRAME_LINEAR_INTERP_CORE_MACROS_SVH
`ifndef ASSERT_OFF
// Implication or plain property checked on every clock edge outside reset.
`define KLI_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never hold outside reset.
`define KLI_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define KLI_ASSERT(lbl, prop, msg)
`define KLI_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

// File: rtl/kli_pkg.sv
// Shared types and constants for the keyframe interpolation core.
// No dependencies.
package kli_pkg;

    localparam int DATA_W   = 32;
    localparam int KIDX_W   = 5;
    localparam int KCNT_W   = 6;
    localparam int SEG_W    = 5;
    localparam int REGION_W = 2;

    // Size of the key table; the index, count and segment widths above are fixed to suit it.
    localparam int MAX_KEYS = 32;

    // Request command codes.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Result region codes.
    localparam logic [REGION_W-1:0] REGION_FIRST  = 2'd0;
    localparam logic [REGION_W-1:0] REGION_INTERP = 2'd1;
    localparam logic [REGION_W-1:0] REGION_LAST   = 2'd2;

    // Component select codes.
    localparam logic [1:0] COMP_X = 2'd0;
    localparam logic [1:0] COMP_Y = 2'd1;
    localparam logic [1:0] COMP_Z = 2'd2;

    // One keyframe as stored in the table memory.
    typedef struct packed {
        logic [DATA_W-1:0] t;
        logic [DATA_W-1:0] x;
        logic [DATA_W-1:0] y;
        logic [DATA_W-1:0] z;
    } kf_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                ld_query;
        logic                ld_prev;
        logic                ld_cur;
        logic                res_from_rd;
        logic                res_from_prev;
        logic                div_start;
        logic                div_step;
        logic                mul_step;
        logic                add_step;
        logic [1:0]          comp;
        logic                set_meta;
        logic [SEG_W-1:0]    seg;
        logic [REGION_W-1:0] region;
        logic                out_load;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic q_le_rd;
        logic hit;
        logic zero_len;
    } dp_status_t;

endpackage

// File: rtl/kli_req_if.sv
// Request channel interface of the keyframe interpolation core.
// Depends on kli_pkg.
interface kli_req_if;
    logic                        valid;
    logic                        ready;
    logic                        command;
    logic [kli_pkg::KIDX_W-1:0]  key_index;
    logic [kli_pkg::DATA_W-1:0]  key_time;
    logic signed [kli_pkg::DATA_W-1:0] key_x;
    logic signed [kli_pkg::DATA_W-1:0] key_y;
    logic signed [kli_pkg::DATA_W-1:0] key_z;
    logic [kli_pkg::DATA_W-1:0]  query_time;

    modport source (output valid, command, key_index, key_time, key_x, key_y, key_z,
                    query_time, input ready);
    modport sink (input valid, command, key_index, key_time, key_x, key_y, key_z,
                  query_time, output ready);
endinterface

// File: rtl/kli_rsp_if.sv
// Result channel interface of the keyframe interpolation core.
// Depends on kli_pkg.
interface kli_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [kli_pkg::DATA_W-1:0]   out_x;
    logic signed [kli_pkg::DATA_W-1:0]   out_y;
    logic signed [kli_pkg::DATA_W-1:0]   out_z;
    logic [kli_pkg::SEG_W-1:0]           segment;
    logic [kli_pkg::REGION_W-1:0]        region;

    modport source (output valid, out_x, out_y, out_z, segment, region, input ready);
    modport sink (input valid, out_x, out_y, out_z, segment, region, output ready);
endinterface

// File: rtl/kli_cfg_if.sv
// Configuration write channel carrying the key count register.
// Depends on kli_pkg.
interface kli_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [kli_pkg::KCNT_W-1:0]  key_count;

    modport source (output valid, key_count, input ready);
    modport sink (input valid, key_count, output ready);
endinterface

// File: rtl/kli_ram.sv
// Generic single write, single read RAM with registered read data.
// No dependencies.
module kli_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 32
) (
    input  logic                                      clk,
    input  logic                                      wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/kli_ctrl.sv
// Controller of the keyframe interpolation core: scan, divide and blend sequencing.
// Depends on kli_pkg.
module kli_ctrl #(
    parameter int MAX_KEYS  = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    input  logic                              req_command,
    output logic                              req_ready,
    input  logic [kli_pkg::KCNT_W-1:0]        key_count,
    input  logic                              out_ready,
    output logic                              out_valid,
    input  kli_pkg::dp_status_t               sts,
    output kli_pkg::ctrl_cmd_t                cmd,
    output logic [(MAX_KEYS > 1 ? $clog2(MAX_KEYS) : 1)-1:0] rd_addr
);

    localparam int IDX_W  = MAX_KEYS > 1 ? $clog2(MAX_KEYS) : 1;
    localparam int CNT_W  = $clog2(MAX_KEYS + 1);
    localparam int DCNT_W = $clog2(FRAC_BITS + 2);

    typedef enum logic [3:0] {
        S_IDLE, S_FETCH0, S_CHK0, S_FETCH, S_CHK, S_DIV, S_MUL, S_ADD, S_DONE
    } state_t;

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [DCNT_W-1:0]  dcnt_reg, dcnt_next;
    logic [1:0]         comp_reg, comp_next;
    logic               out_valid_reg, out_valid_next;
    logic [31:0]        kc32;
    logic [31:0]        cnt_clamp;
    logic [31:0]        idx32;
    logic [31:0]        idx_m1;
    logic               is_last;

    // Effective key count: zero acts as one, large values saturate.
    assign kc32 = 32'(key_count);
    always_comb
    begin
        priority if (kc32 == 32'd0)
            cnt_clamp = 32'd1;
        else if (kc32 > 32'(MAX_KEYS))
            cnt_clamp = 32'(MAX_KEYS);
        else
            cnt_clamp = kc32;
    end

    assign idx32   = 32'(idx_reg);
    assign idx_m1  = idx32 - 32'd1;
    assign is_last = (idx32 + 32'd1) == 32'(cnt_reg);

    assign req_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign rd_addr   = idx_reg;

    // Next state and command decode.
    always_comb
    begin
        cmd        = '0;
        cmd.comp   = comp_reg;
        state_next = state_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        dcnt_next  = dcnt_reg;
        comp_next  = comp_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid && req_command == kli_pkg::CMD_QUERY)
                begin
                    cmd.ld_query = 1'b1;
                    idx_next     = '0;
                    cnt_next     = CNT_W'(cnt_clamp);
                    state_next   = S_FETCH0;
                end
            end
            S_FETCH0:
            begin
                state_next = S_CHK0;
            end
            S_CHK0:
            begin
                cmd.ld_prev = 1'b1;
                if (cnt_reg == CNT_W'(1) || sts.q_le_rd)
                begin
                    cmd.res_from_rd = 1'b1;
                    cmd.set_meta    = 1'b1;
                    cmd.seg         = '0;
                    cmd.region      = kli_pkg::REGION_FIRST;
                    state_next      = S_DONE;
                end
                else
                begin
                    idx_next   = IDX_W'(1);
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                state_next = S_CHK;
            end
            S_CHK:
            begin
                priority if (sts.hit)
                begin
                    cmd.set_meta = 1'b1;
                    cmd.seg      = idx_m1[kli_pkg::SEG_W-1:0];
                    cmd.region   = kli_pkg::REGION_INTERP;
                    if (sts.zero_len)
                    begin
                        // Zero-length segment holds its start value.
                        cmd.res_from_prev = 1'b1;
                        state_next        = S_DONE;
                    end
                    else
                    begin
                        cmd.ld_cur    = 1'b1;
                        cmd.div_start = 1'b1;
                        dcnt_next     = '0;
                        state_next    = S_DIV;
                    end
                end
                else if (is_last)
                begin
                    cmd.res_from_rd = 1'b1;
                    cmd.set_meta    = 1'b1;
                    cmd.seg         = idx32[kli_pkg::SEG_W-1:0];
                    cmd.region      = kli_pkg::REGION_LAST;
                    state_next      = S_DONE;
                end
                else
                begin
                    cmd.ld_prev = 1'b1;
                    idx_next    = idx_reg + IDX_W'(1);
                    state_next  = S_FETCH;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (dcnt_reg == DCNT_W'(FRAC_BITS))
                begin
                    comp_next  = kli_pkg::COMP_X;
                    state_next = S_MUL;
                end
                else
                begin
                    dcnt_next = dcnt_reg + DCNT_W'(1);
                end
            end
            S_MUL:
            begin
                cmd.mul_step = 1'b1;
                state_next   = S_ADD;
            end
            S_ADD:
            begin
                cmd.add_step = 1'b1;
                if (comp_reg == kli_pkg::COMP_Z)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    comp_next  = comp_reg + 2'd1;
                    state_next = S_MUL;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid: set when a result is loaded, cleared when taken.
    always_comb
    begin
        priority if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            cnt_reg       <= CNT_W'(1);
            dcnt_reg      <= '0;
            comp_reg      <= kli_pkg::COMP_X;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            dcnt_reg      <= dcnt_next;
            comp_reg      <= comp_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: rtl/kli_dp.sv
// Datapath of the keyframe interpolation core: compare, serial divider, shared multiplier.
// Depends on kli_pkg.
module kli_dp #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                 clk,
    input  kli_pkg::ctrl_cmd_t                   cmd,
    input  kli_pkg::kf_t                         rdata,
    input  logic [kli_pkg::DATA_W-1:0]           query_time,
    output kli_pkg::dp_status_t                  sts,
    output logic signed [kli_pkg::DATA_W-1:0]    out_x,
    output logic signed [kli_pkg::DATA_W-1:0]    out_y,
    output logic signed [kli_pkg::DATA_W-1:0]    out_z,
    output logic [kli_pkg::SEG_W-1:0]            segment,
    output logic [kli_pkg::REGION_W-1:0]         region
);

    localparam int DW     = kli_pkg::DATA_W;
    localparam int PROD_W = DW + FRAC_BITS + 3;

    logic [DW-1:0]             q_reg;
    kli_pkg::kf_t              prev_reg;
    kli_pkg::kf_t              cur_reg;
    logic [DW:0]               rem_reg;
    logic [DW-1:0]             dv_reg;
    logic [FRAC_BITS:0]        quo_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic [DW-1:0]             res_x_reg, res_y_reg, res_z_reg;
    logic [kli_pkg::SEG_W-1:0]    seg_reg;
    logic [kli_pkg::REGION_W-1:0] region_reg;
    logic [DW-1:0]             out_x_reg, out_y_reg, out_z_reg;
    logic [kli_pkg::SEG_W-1:0]    out_seg_reg;
    logic [kli_pkg::REGION_W-1:0] out_region_reg;

    logic                      div_ge;
    logic [DW:0]               rem_sub;
    logic [DW-1:0]             v0, v1;
    logic signed [DW:0]        diff;
    logic signed [FRAC_BITS+1:0] fac;
    logic signed [PROD_W-1:0]  prod_full;
    logic signed [PROD_W-1:0]  prod_shift;
    logic [DW-1:0]             blend;

    // Segment tests against the key just read.
    assign sts.q_le_rd  = q_reg <= rdata.t;
    assign sts.hit      = (prev_reg.t <= q_reg) && (q_reg <= rdata.t);
    assign sts.zero_len = rdata.t == prev_reg.t;

    // Restoring divider step, one quotient bit a cycle.
    assign div_ge  = rem_reg >= {1'b0, dv_reg};
    assign rem_sub = div_ge ? (rem_reg - {1'b0, dv_reg}) : rem_reg;

    // Component selection for the shared multiplier and adder.
    always_comb
    begin
        unique case (cmd.comp)
            kli_pkg::COMP_X:
            begin
                v0 = prev_reg.x;
                v1 = cur_reg.x;
            end
            kli_pkg::COMP_Y:
            begin
                v0 = prev_reg.y;
                v1 = cur_reg.y;
            end
            kli_pkg::COMP_Z:
            begin
                v0 = prev_reg.z;
                v1 = cur_reg.z;
            end
            default:
            begin
                v0 = prev_reg.x;
                v1 = cur_reg.x;
            end
        endcase
    end

    assign diff       = $signed({v1[DW-1], v1}) - $signed({v0[DW-1], v0});
    assign fac        = $signed({1'b0, quo_reg});
    // The product is formed at full width so no high bits are lost.
    assign prod_full  = diff * fac;
    // Arithmetic shift floors toward minus infinity.
    assign prod_shift = prod_reg >>> FRAC_BITS;
    assign blend      = v0 + prod_shift[DW-1:0];

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (cmd.ld_query)
        begin
            q_reg <= query_time;
        end
        if (cmd.ld_prev)
        begin
            prev_reg <= rdata;
        end
        if (cmd.ld_cur)
        begin
            cur_reg <= rdata;
        end
        if (cmd.div_start)
        begin
            rem_reg <= {1'b0, q_reg - prev_reg.t};
            dv_reg  <= rdata.t - prev_reg.t;
            quo_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= {rem_sub[DW-1:0], 1'b0};
            quo_reg <= {quo_reg[FRAC_BITS-1:0], div_ge};
        end
        if (cmd.mul_step)
        begin
            prod_reg <= prod_full;
        end
        if (cmd.res_from_rd)
        begin
            res_x_reg <= rdata.x;
            res_y_reg <= rdata.y;
            res_z_reg <= rdata.z;
        end
        else if (cmd.res_from_prev)
        begin
            res_x_reg <= prev_reg.x;
            res_y_reg <= prev_reg.y;
            res_z_reg <= prev_reg.z;
        end
        else if (cmd.add_step)
        begin
            unique case (cmd.comp)
                kli_pkg::COMP_X: res_x_reg <= blend;
                kli_pkg::COMP_Y: res_y_reg <= blend;
                kli_pkg::COMP_Z: res_z_reg <= blend;
                default:         res_x_reg <= blend;
            endcase
        end
        if (cmd.set_meta)
        begin
            seg_reg    <= cmd.seg;
            region_reg <= cmd.region;
        end
        if (cmd.out_load)
        begin
            out_x_reg      <= res_x_reg;
            out_y_reg      <= res_y_reg;
            out_z_reg      <= res_z_reg;
            out_seg_reg    <= seg_reg;
            out_region_reg <= region_reg;
        end
    end

    assign out_x   = $signed(out_x_reg);
    assign out_y   = $signed(out_y_reg);
    assign out_z   = $signed(out_z_reg);
    assign segment = out_seg_reg;
    assign region  = out_region_reg;

endmodule

// File: rtl/keyframe_linear_interp_core.sv
// Keyframe linear interpolation core. A write goes straight to the key table and gives no result.
// A query reads keys one at a time, in a fetch state and a check state per key scanned,
// then runs a serial divide for FRAC_BITS+1 quotient bits and three multiply-add passes.
// When a key value is held (first, last or zero-length segment) the divide and blend are
// skipped; only one query is in flight, the next request is taken once its result is loaded.
// Reset clears control state and sets key_count to 1; the key table is not cleared.
`include "keyframe_linear_interp_core_macros.svh"
module keyframe_linear_interp_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    kli_req_if.sink    req,
    kli_rsp_if.source  rsp,
    kli_cfg_if.sink    cfg
);

    localparam int MAX_KEYS = kli_pkg::MAX_KEYS;
    localparam int IDX_W    = MAX_KEYS > 1 ? $clog2(MAX_KEYS) : 1;
    localparam int KF_W     = $bits(kli_pkg::kf_t);

    logic [kli_pkg::KCNT_W-1:0] key_count_reg;
    kli_pkg::ctrl_cmd_t         cmd;
    kli_pkg::dp_status_t        sts;
    kli_pkg::kf_t               wr_kf;
    kli_pkg::kf_t               rd_kf;
    logic [KF_W-1:0]            rd_raw;
    logic [IDX_W-1:0]           rd_addr;
    logic [31:0]                wr_idx32;
    logic                       wr_en;

    // Key count register.
    assign cfg.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_count_reg <= kli_pkg::KCNT_W'(1);
        end
        else if (cfg.valid)
        begin
            key_count_reg <= cfg.key_count;
        end
    end

    // Keyframe writes go straight to the table; indexes past the table are dropped.
    assign wr_idx32 = 32'(req.key_index);
    assign wr_en    = req.valid && req.ready && req.command == kli_pkg::CMD_WRITE
                      && wr_idx32 < 32'(MAX_KEYS);
    assign wr_kf.t  = req.key_time;
    assign wr_kf.x  = req.key_x;
    assign wr_kf.y  = req.key_y;
    assign wr_kf.z  = req.key_z;
    assign rd_kf    = kli_pkg::kf_t'(rd_raw);

    kli_ram #(
        .WIDTH (KF_W),
        .DEPTH (MAX_KEYS)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_idx32[IDX_W-1:0]),
        .wr_data (wr_kf),
        .rd_addr (rd_addr),
        .rd_data (rd_raw)
    );

    kli_ctrl #(
        .MAX_KEYS  (MAX_KEYS),
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req.valid),
        .req_command (req.command),
        .req_ready   (req.ready),
        .key_count   (key_count_reg),
        .out_ready   (rsp.ready),
        .out_valid   (rsp.valid),
        .sts         (sts),
        .cmd         (cmd),
        .rd_addr     (rd_addr)
    );

    kli_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk        (clk),
        .cmd        (cmd),
        .rdata      (rd_kf),
        .query_time (req.query_time),
        .sts        (sts),
        .out_x      (rsp.out_x),
        .out_y      (rsp.out_y),
        .out_z      (rsp.out_z),
        .segment    (rsp.segment),
        .region     (rsp.region)
    );

    // A write request never produces a result.
    `KLI_ASSERT(a_write_no_rsp, req.valid && req.ready && req.command == kli_pkg::CMD_WRITE && !rsp.valid |=> !rsp.valid, "write request produced a result")
    // A query keeps the request side busy in the following cycle.
    `KLI_ASSERT(a_query_busy, req.valid && req.ready && req.command == kli_pkg::CMD_QUERY |=> !req.ready, "request accepted while a query is in progress")
    // The first value is always reported against segment zero.
    `KLI_ASSERT_NEVER(a_first_seg, rsp.valid && rsp.region == kli_pkg::REGION_FIRST && rsp.segment != '0, "first-value result with nonzero segment")

endmodule

// File: verif/keyframe_linear_interp_core_tb.sv
// Self-checking testbench for keyframe_linear_interp_core: loads key tables,
// issues queries under random stalls and compares every result with a local predictor.
// Depends on kli_pkg, the three channel interfaces and the core itself.
module keyframe_linear_interp_core_tb;

    localparam int DATA_W   = kli_pkg::DATA_W;
    localparam int SEG_W    = kli_pkg::SEG_W;
    localparam int REGION_W = kli_pkg::REGION_W;
    localparam int KCNT_W   = kli_pkg::KCNT_W;
    localparam int KIDX_W   = kli_pkg::KIDX_W;

    localparam int NUM_KEYS     = 32;
    localparam int FRAC         = 16;
    localparam int SETTLE_CYC   = 100;
    localparam int WATCHDOG_LIM = 4000;
    localparam int RANDOM_ITEMS = 600;

    typedef struct {
        logic [DATA_W-1:0]   x;
        logic [DATA_W-1:0]   y;
        logic [DATA_W-1:0]   z;
        logic [SEG_W-1:0]    seg;
        logic [REGION_W-1:0] region;
    } interp_res_t;

    logic clk;
    logic rst_n;

    kli_req_if req_ch ();
    kli_rsp_if rsp_ch ();
    kli_cfg_if cfg_ch ();

    keyframe_linear_interp_core DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // Local copy of the key table and the key count register.
    logic [DATA_W-1:0] key_t_tbl [NUM_KEYS];
    logic [DATA_W-1:0] key_x_tbl [NUM_KEYS];
    logic [DATA_W-1:0] key_y_tbl [NUM_KEYS];
    logic [DATA_W-1:0] key_z_tbl [NUM_KEYS];
    logic [KCNT_W-1:0] key_cnt;

    interp_res_t pending_vectors [$];
    int  error_count;
    int  items_sent;
    bit  no_gaps;
    int  rsp_hold;
    int  rsp_stall;
    int  idle_cycles;

    // Clock generation.
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // One component of the blend, floored toward minus infinity.
    function automatic logic [DATA_W-1:0] blend_comp(logic [DATA_W-1:0] a,
                                                     logic [DATA_W-1:0] b,
                                                     longint f);
        longint v0;
        longint d;
        longint p;
        v0 = longint'($signed(a));
        d  = longint'($signed(b)) - v0;
        p  = d * f;
        return DATA_W'(v0 + (p >>> FRAC));
    endfunction

    function automatic interp_res_t blend_keys(int k, int n, longint f, int seg,
                                               logic [REGION_W-1:0] region);
        interp_res_t r;
        r.x      = blend_comp(key_x_tbl[k], key_x_tbl[n], f);
        r.y      = blend_comp(key_y_tbl[k], key_y_tbl[n], f);
        r.z      = blend_comp(key_z_tbl[k], key_z_tbl[n], f);
        r.seg    = SEG_W'(seg);
        r.region = region;
        return r;
    endfunction

    // Expected result of a query at time q under the current table and count.
    function automatic interp_res_t interpolate_at(logic [DATA_W-1:0] q);
        int n;
        logic [DATA_W-1:0] t0;
        logic [DATA_W-1:0] t1;
        longint unsigned num;
        longint unsigned f;
        n = int'(key_cnt);
        if (n < 1)
            n = 1;
        if (n > NUM_KEYS)
            n = NUM_KEYS;
        if (n == 1 || q <= key_t_tbl[0])
            return blend_keys(0, 0, 0, 0, kli_pkg::REGION_FIRST);
        for (int i = 0; i + 1 < n; i++)
        begin
            t0 = key_t_tbl[i];
            t1 = key_t_tbl[i + 1];
            if (t0 <= q && q <= t1)
            begin
                // A zero-length segment holds its start value.
                if (t0 == t1)
                    return blend_keys(i, i, 0, i, kli_pkg::REGION_INTERP);
                num = longint'(q - t0) << FRAC;
                f   = num / longint'(t1 - t0);
                return blend_keys(i, i + 1, longint'(f), i, kli_pkg::REGION_INTERP);
            end
        end
        return blend_keys(n - 1, n - 1, 0, n - 1, kli_pkg::REGION_LAST);
    endfunction

    // Result side: random stalls, long hold-offs and the field check.
    always @(posedge clk)
    begin
        interp_res_t exp_r;
        int s;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (pending_vectors.size() == 0)
                begin
                    $display("%0t: result with nothing expected", $time);
                    error_count++;
                end
                else
                begin
                    exp_r = pending_vectors.pop_front();
                    if (rsp_ch.out_x !== exp_r.x || rsp_ch.out_y !== exp_r.y ||
                        rsp_ch.out_z !== exp_r.z || rsp_ch.segment !== exp_r.seg ||
                        rsp_ch.region !== exp_r.region)
                    begin
                        $display("%0t: mismatch expected x=%h y=%h z=%h seg=%0d reg=%0d",
                                 $time, exp_r.x, exp_r.y, exp_r.z, exp_r.seg, exp_r.region);
                        $display("%0t:          actual   x=%h y=%h z=%h seg=%0d reg=%0d",
                                 $time, rsp_ch.out_x, rsp_ch.out_y, rsp_ch.out_z,
                                 rsp_ch.segment, rsp_ch.region);
                        error_count++;
                    end
                end
            end
            if (rsp_hold > 0)
            begin
                rsp_ch.ready <= 1'b0;
                rsp_hold--;
            end
            else if (rsp_stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                rsp_stall--;
            end
            else if (rsp_ch.valid && rsp_ch.ready)
            begin
                s = no_gaps ? 0 : $urandom_range(0, 6);
                rsp_ch.ready <= (s == 0);
                rsp_stall = (s > 0) ? s - 1 : 0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles without any accepted transfer.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIM)
            begin
                $display("%0t: watchdog expired", $time);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Sends one request and updates the predictor when it is accepted.
    // Valid stays high on return only when the next request follows at once.
    task automatic send_request(logic cmd, logic [KIDX_W-1:0] idx, logic [DATA_W-1:0] kt,
                                logic [DATA_W-1:0] kx, logic [DATA_W-1:0] ky,
                                logic [DATA_W-1:0] kz, logic [DATA_W-1:0] qt);
        int gap;
        req_ch.valid      <= 1'b1;
        req_ch.command    <= cmd;
        req_ch.key_index  <= idx;
        req_ch.key_time   <= kt;
        req_ch.key_x      <= kx;
        req_ch.key_y      <= ky;
        req_ch.key_z      <= kz;
        req_ch.query_time <= qt;
        do
            @(posedge clk);
        while (!req_ch.ready);
        if (cmd == kli_pkg::CMD_WRITE)
        begin
            key_t_tbl[idx] = kt;
            key_x_tbl[idx] = kx;
            key_y_tbl[idx] = ky;
            key_z_tbl[idx] = kz;
        end
        else
        begin
            pending_vectors.push_back(interpolate_at(qt));
        end
        items_sent++;
        gap = no_gaps ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_key(int idx, logic [DATA_W-1:0] kt, logic [DATA_W-1:0] kx,
                             logic [DATA_W-1:0] ky, logic [DATA_W-1:0] kz);
        send_request(kli_pkg::CMD_WRITE, KIDX_W'(idx), kt, kx, ky, kz, $urandom());
    endtask

    task automatic query_at(logic [DATA_W-1:0] qt);
        send_request(kli_pkg::CMD_QUERY, KIDX_W'($urandom()), $urandom(), $urandom(),
                     $urandom(), $urandom(), qt);
    endtask

    // Drops valid and waits until every expected result is in and the core is idle.
    task automatic drain;
        req_ch.valid <= 1'b0;
        while (pending_vectors.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic set_key_count(logic [KCNT_W-1:0] n);
        drain();
        cfg_ch.valid     <= 1'b1;
        cfg_ch.key_count <= n;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        key_cnt = n;
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Directed: boundary values, each region, zero-length segment and scan order.
    task automatic test_directed;
        write_key(0, 32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
        write_key(1, 32'h0003_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        write_key(2, 32'h0005_0000, 32'h0000_1234, 32'hFFFF_0000, 32'h0001_0000);
        write_key(3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000);
        query_at(32'h0002_0000);
        set_key_count(6'd4);
        query_at(32'h0000_0000);
        query_at(32'h0001_0000);
        query_at(32'h0001_0001);
        query_at(32'h0002_8000);
        query_at(32'h0003_0000);
        query_at(32'h0004_0000);
        query_at(32'hFFFF_FFFE);
        query_at(32'hFFFF_FFFF);
        write_key(2, 32'h0003_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        query_at(32'h0003_0000);
        query_at(32'h0003_0001);
        set_key_count(6'd3);
        query_at(32'h8000_0000);
        set_key_count(6'd1);
        query_at(32'hFFFF_FFFF);
        query_at(32'h0000_0000);
        drain();
    endtask

    // Random: load a table with mostly ascending times, then query around it.
    task automatic test_random;
        int n;
        int phase;
        int nq;
        bit sorted;
        logic [DATA_W-1:0] t;
        logic [DATA_W-1:0] q;
        logic [KCNT_W-1:0] cnt;
        phase = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 7))
                0: cnt = 6'd0;
                1: cnt = 6'd63;
                2: cnt = 6'd33;
                3: cnt = 6'd32;
                default: cnt = KCNT_W'($urandom_range(1, 32));
            endcase
            if (phase == 0)
                cnt = 6'd32;
            n = (cnt == 0) ? 1 : ((cnt > NUM_KEYS) ? NUM_KEYS : int'(cnt));
            no_gaps = ($urandom_range(0, 3) == 0);
            sorted = ($urandom_range(0, 5) != 0);
            set_key_count(cnt);
            t = $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 32'h0010_0000);
            for (int i = 0; i < n; i++)
            begin
                write_key(i, sorted ? t : $urandom(), $urandom(), $urandom(), $urandom());
                if ($urandom_range(0, 7) != 0)
                    t = t + $urandom_range(1, 32'h0004_0000);
            end
            nq = 2 * n + 4;
            for (int j = 0; j < nq; j++)
            begin
                case ($urandom_range(0, 5))
                    0: q = $urandom();
                    1: q = key_t_tbl[$urandom_range(0, n - 1)];
                    default: q = key_t_tbl[$urandom_range(0, n - 1)] +
                                 $urandom_range(0, 32'h0004_0000) - 32'h0001_0000;
                endcase
                query_at(q);
                // Writes to entries beyond the count do not touch the active keys.
                if (n < NUM_KEYS && $urandom_range(0, 9) == 0)
                    write_key($urandom_range(n, NUM_KEYS - 1), $urandom(), $urandom(),
                              $urandom(), $urandom());
            end
            phase++;
        end
        no_gaps = 1'b0;
        drain();
    endtask

    // Holds the result side off for a long stretch while queries keep coming.
    task automatic test_backpressure;
        set_key_count(6'd32);
        rsp_hold = 300;
        for (int j = 0; j < 20; j++)
            query_at($urandom_range(0, key_t_tbl[31]));
        drain();
    endtask

    // Pauses the sender until every result is in, then continues.
    task automatic test_pause;
        for (int j = 0; j < 8; j++)
            query_at($urandom());
        drain();
        for (int j = 0; j < 8; j++)
            query_at($urandom());
        drain();
    endtask

    initial
    begin
        error_count = 0;
        items_sent  = 0;
        no_gaps     = 1'b0;
        rsp_hold    = 0;
        rsp_stall   = 0;
        idle_cycles = 0;
        key_cnt     = 6'd1;
        rst_n             <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.command    <= kli_pkg::CMD_WRITE;
        req_ch.key_index  <= '0;
        req_ch.key_time   <= '0;
        req_ch.key_x      <= '0;
        req_ch.key_y      <= '0;
        req_ch.key_z      <= '0;
        req_ch.query_time <= '0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.key_count  <= 6'd1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random();
        test_backpressure();
        test_pause();

        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
